// ===== design/bpa_pkg.sv =====
// Shared constants, codes and helper functions of the bitmap page allocator.
// Used by the top level, the port checker, the grant checker and the testbench top.
// No dependencies.
package bpa_pkg;

  localparam int DEF_NUM_PAGES = 8192;

  localparam int CMD_W   = 2;
  localparam int CNT_W   = 14;
  localparam int ALIGN_W = 4;
  localparam int PAGE_W  = 13;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 14;
  localparam int CFG_IDX_W = 1;

  localparam int WORD_BITS = 32;
  localparam int WB_LOG    = 5;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 1'd1;

  localparam logic [CFG_W-1:0] TOTAL_RST    = 14'd8192;
  localparam logic [CFG_W-1:0] RESERVED_RST = 14'd4096;

  // Bits lo up to hi (exclusive) of a word set; both bounds range from 0 to 32.
  function automatic logic [WORD_BITS-1:0] range_mask(input logic [WB_LOG:0] lo,
                                                      input logic [WB_LOG:0] hi);
    logic [WORD_BITS:0] a;
    logic [WORD_BITS:0] b;
    a = ((WORD_BITS+1)'(1) << hi) - (WORD_BITS+1)'(1);
    b = ((WORD_BITS+1)'(1) << lo) - (WORD_BITS+1)'(1);
    return a[WORD_BITS-1:0] & ~b[WORD_BITS-1:0];
  endfunction

  // Position of the lowest set bit of a word.
  function automatic logic [WB_LOG-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [WB_LOG-1:0] k;
    k = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        k = WB_LOG'(i);
      end
    end
    return k;
  endfunction

endpackage

// ===== design/bpa_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bitmap_page_allocator_top.sv =====
// Top level of the bitmap page allocator: request handling, bitmap scan and sweep control.
// Depends on bpa_pkg and on bpa_ram, which holds the page bitmap 32 pages to a word.
//
//   Channel | Direction | Handshake              | Payload
//   request | in        | in_valid_i / in_stall_o  | cmd_i, page_count_i, align_log2_i, start_page_i
//   result  | out       | out_valid_o / out_stall_i| status_o, base_page_o
//   config  | in        | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// One request is processed at a time; the bitmap RAM port sets the pace at one 32-page word
// per cycle. Allocate reads the words of each candidate run and moves to the next aligned
// base past a busy page, then marks the run in a read-modify-write sweep. Free clears its
// range in such a sweep, and initialize rewrites every word. After reset the bitmap is
// cleared while requests are stalled. A finished result waits in the output register
// while the next request is taken.
module bitmap_page_allocator_top
  import bpa_pkg::*;
#(
  parameter int NUM_PAGES = DEF_NUM_PAGES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic [CNT_W-1:0]     page_count_i,
  input  logic [ALIGN_W-1:0]   align_log2_i,
  input  logic [PAGE_W-1:0]    start_page_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STAT_W-1:0]    status_o,
  output logic [PAGE_W-1:0]    base_page_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int PW    = $clog2(NUM_PAGES);
  localparam int IW    = ((PW > 15) ? PW : 15) + 2;
  localparam int WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [IW-1:0]  NUM_IW    = IW'(NUM_PAGES);
  localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ARD  = 3'd1;
  localparam logic [2:0] S_AEV  = 3'd2;
  localparam logic [2:0] S_SRD  = 3'd3;
  localparam logic [2:0] S_SWR  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [1:0] M_INIT = 2'd0;
  localparam logic [1:0] M_SET  = 2'd1;
  localparam logic [1:0] M_CLR  = 2'd2;

  logic [2:0]        state_q, state_d;
  logic              phase_q, phase_d;
  logic [PW-1:0]     last_q, last_d;
  logic [1:0]        sw_mode_q, sw_mode_d;
  logic [IW-1:0]     sw_lo_q, sw_lo_d;
  logic [IW-1:0]     sw_hi_q, sw_hi_d;
  logic [WAW-1:0]    sw_w_q, sw_w_d;
  logic [WAW-1:0]    sw_last_q, sw_last_d;
  logic              sw_res_q, sw_res_d;
  logic              out_valid_q, out_valid_d;
  logic [CFG_W-1:0]  total_q, total_d;
  logic [CFG_W-1:0]  reserved_q, reserved_d;

  logic [IW-1:0]     b_q, b_d;
  logic [IW-1:0]     t_q, t_d;
  logic [IW-1:0]     run_end_q, run_end_d;
  logic [IW-1:0]     hi_q, hi_d;
  logic [IW-1:0]     alm_q, alm_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [STAT_W-1:0] res_status_q, res_status_d;
  logic [PAGE_W-1:0] res_base_q, res_base_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [PAGE_W-1:0] base_q, base_d;

  logic                 ram_we;
  logic                 ram_re;
  logic [WAW-1:0]       ram_waddr;
  logic [WAW-1:0]       ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [IW-1:0] lim, rsv, last_ext, hi1, in_alm, lo0, b0, cnt_ext, fend, fend_m1;
  logic          free_ok;
  logic [IW-1:0] sum_rd;
  logic          fail_rd;
  logic [IW-1:0] word_base, span, tp, nb, run_m1;
  logic [WB_LOG:0] ev_lo, ev_hi;
  logic [WORD_BITS-1:0] ev_mask, hits;
  logic          cont;
  logic [IW-1:0] sw_base, lo_diff, hi_diff;
  logic [WB_LOG:0] sw_lo_rel, sw_hi_rel;
  logic [WORD_BITS-1:0] sw_mask;

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS),
    .AW    (WAW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    lim      = (IW'(total_q) < NUM_IW) ? IW'(total_q) : NUM_IW;
    rsv      = (IW'(reserved_q) < NUM_IW) ? IW'(reserved_q) : NUM_IW;
    last_ext = IW'(last_q);
    hi1      = (last_ext < lim) ? last_ext : lim;
    in_alm   = (IW'(1) << align_log2_i) - IW'(1);
    lo0      = last_ext + IW'(1);
    b0       = (lo0 + in_alm) & ~in_alm;
    cnt_ext  = IW'(page_count_i);
    fend     = IW'(start_page_i) + cnt_ext;
    fend_m1  = fend - IW'(1);
    free_ok  = (page_count_i != '0) && (fend <= lim);

    sum_rd  = b_q + IW'(cnt_q);
    fail_rd = (b_q >= hi_q) || (sum_rd > hi_q);

    word_base = {t_q[IW-1:WB_LOG], {WB_LOG{1'b0}}};
    span      = run_end_q - word_base;
    cont      = span > IW'(WORD_BITS);
    ev_lo     = {1'b0, t_q[WB_LOG-1:0]};
    ev_hi     = cont ? (WB_LOG+1)'(WORD_BITS) : span[WB_LOG:0];
    ev_mask   = range_mask(ev_lo, ev_hi);
    hits      = ram_rdata & ev_mask;
    tp        = word_base + IW'(lowest_set(hits));
    nb        = (tp + IW'(1) + alm_q) & ~alm_q;
    run_m1    = run_end_q - IW'(1);

    sw_base = {{(IW-WAW-WB_LOG){1'b0}}, sw_w_q, {WB_LOG{1'b0}}};
    lo_diff = sw_lo_q - sw_base;
    hi_diff = sw_hi_q - sw_base;
    if (sw_lo_q <= sw_base) begin
      sw_lo_rel = '0;
    end else if (lo_diff >= IW'(WORD_BITS)) begin
      sw_lo_rel = (WB_LOG+1)'(WORD_BITS);
    end else begin
      sw_lo_rel = lo_diff[WB_LOG:0];
    end
    if (sw_hi_q <= sw_base) begin
      sw_hi_rel = '0;
    end else if (hi_diff >= IW'(WORD_BITS)) begin
      sw_hi_rel = (WB_LOG+1)'(WORD_BITS);
    end else begin
      sw_hi_rel = hi_diff[WB_LOG:0];
    end
    sw_mask = range_mask(sw_lo_rel, sw_hi_rel);
  end

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    last_d       = last_q;
    sw_mode_d    = sw_mode_q;
    sw_lo_d      = sw_lo_q;
    sw_hi_d      = sw_hi_q;
    sw_w_d       = sw_w_q;
    sw_last_d    = sw_last_q;
    sw_res_d     = sw_res_q;
    out_valid_d  = out_valid_q;
    total_d      = total_q;
    reserved_d   = reserved_q;
    b_d          = b_q;
    t_d          = t_q;
    run_end_d    = run_end_q;
    hi_d         = hi_q;
    alm_d        = alm_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_base_d   = res_base_q;
    status_d     = status_q;
    base_d       = base_q;

    ram_we    = 1'b0;
    ram_waddr = sw_w_q;
    ram_re    = 1'b0;
    ram_raddr = sw_w_q;
    case (sw_mode_q)
      M_SET:   ram_wdata = ram_rdata | sw_mask;
      M_CLR:   ram_wdata = ram_rdata & ~sw_mask;
      default: ram_wdata = sw_mask;
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TOTAL:    total_d = cfg_wdata_i;
        REG_RESERVED: reserved_d = cfg_wdata_i;
        default:      ;
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_status_d = ST_BAD;
          res_base_d   = '0;
          sw_res_d     = 1'b1;
          state_d      = S_DONE;
          case (cmd_i)
            CMD_ALLOC: begin
              if (page_count_i != '0) begin
                cnt_d   = page_count_i;
                alm_d   = in_alm;
                hi_d    = lim;
                b_d     = b0;
                phase_d = 1'b0;
                state_d = S_ARD;
              end
            end
            CMD_FREE: begin
              if (free_ok) begin
                res_status_d = ST_OK;
                sw_mode_d    = M_CLR;
                sw_lo_d      = IW'(start_page_i);
                sw_hi_d      = fend;
                sw_w_d       = start_page_i[WB_LOG +: WAW];
                sw_last_d    = fend_m1[WB_LOG +: WAW];
                state_d      = S_SRD;
              end
            end
            CMD_INIT: begin
              res_status_d = ST_OK;
              last_d       = (rsv == '0) ? PW'(NUM_PAGES - 1) : PW'(rsv - IW'(1));
              sw_mode_d    = M_INIT;
              sw_lo_d      = '0;
              sw_hi_d      = rsv;
              sw_w_d       = '0;
              sw_last_d    = LAST_WORD;
              state_d      = S_SRD;
            end
            default: ;
          endcase
        end
      end
      S_ARD: begin
        if (fail_rd) begin
          if (!phase_q) begin
            phase_d = 1'b1;
            hi_d    = hi1;
            b_d     = '0;
          end else begin
            res_status_d = ST_NOSPACE;
            state_d      = S_DONE;
          end
        end else begin
          run_end_d = sum_rd;
          t_d       = b_q;
          ram_re    = 1'b1;
          ram_raddr = b_q[WB_LOG +: WAW];
          state_d   = S_AEV;
        end
      end
      S_AEV: begin
        if (hits != '0) begin
          b_d     = nb;
          state_d = S_ARD;
        end else if (cont) begin
          t_d       = word_base + IW'(WORD_BITS);
          ram_re    = 1'b1;
          ram_raddr = t_q[WB_LOG +: WAW] + WAW'(1);
        end else begin
          res_status_d = ST_OK;
          res_base_d   = b_q[PAGE_W-1:0];
          last_d       = run_m1[PW-1:0];
          sw_mode_d    = M_SET;
          sw_lo_d      = b_q;
          sw_hi_d      = run_end_q;
          sw_w_d       = b_q[WB_LOG +: WAW];
          sw_last_d    = run_m1[WB_LOG +: WAW];
          state_d      = S_SRD;
        end
      end
      S_SRD: begin
        ram_re  = 1'b1;
        state_d = S_SWR;
      end
      S_SWR: begin
        ram_we = 1'b1;
        if (sw_w_q != sw_last_q) begin
          ram_re    = 1'b1;
          ram_raddr = sw_w_q + WAW'(1);
          sw_w_d    = sw_w_q + WAW'(1);
        end else begin
          state_d = sw_res_q ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          base_d      = (res_status_q == ST_OK) ? res_base_q : '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SRD;
      phase_q     <= 1'b0;
      last_q      <= '0;
      sw_mode_q   <= M_INIT;
      sw_lo_q     <= '0;
      sw_hi_q     <= '0;
      sw_w_q      <= '0;
      sw_last_q   <= LAST_WORD;
      sw_res_q    <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= TOTAL_RST;
      reserved_q  <= RESERVED_RST;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      last_q      <= last_d;
      sw_mode_q   <= sw_mode_d;
      sw_lo_q     <= sw_lo_d;
      sw_hi_q     <= sw_hi_d;
      sw_w_q      <= sw_w_d;
      sw_last_q   <= sw_last_d;
      sw_res_q    <= sw_res_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
      reserved_q  <= reserved_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q          <= b_d;
    t_q          <= t_d;
    run_end_q    <= run_end_d;
    hi_q         <= hi_d;
    alm_q        <= alm_d;
    cnt_q        <= cnt_d;
    res_status_q <= res_status_d;
    res_base_q   <= res_base_d;
    status_q     <= status_d;
    base_q       <= base_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign base_page_o = base_q;

endmodule

// ===== design/bpa_checker.sv =====
// Port-level checker for the bitmap page allocator, bound to the top level.
// Depends on bpa_pkg and on the port list of bitmap_page_allocator_top.
module bpa_checker
  import bpa_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [STAT_W-1:0]    status_o,
  input logic [PAGE_W-1:0]    base_page_o
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] open_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (in_acc && !out_acc) begin
      open_q <= open_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      open_q <= open_q - 2'd1;
    end
  end

  a_open_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q != 2'd3)
    else $error("more than two requests without a delivered result");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("request taken without the block becoming busy");

  a_base_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> base_page_o == '0)
    else $error("nonzero base page on a failed request");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(base_page_o)))
    else $error("stalled result changed");

endmodule

bind bitmap_page_allocator_top bpa_checker u_bpa_checker (.*);

// ===== tb/bpa_grant_checker.sv =====
`timescale 1ns / 100ps
// Checker for the bitmap page allocator: watches the request, result and register ports,
// predicts each result from its own copy of the page map and compares. Depends on bpa_pkg.
module bpa_grant_checker
  import bpa_pkg::*;
#(
  parameter int NUM_PAGES = DEF_NUM_PAGES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  logic                 req_stall_i,
  input  logic [CMD_W-1:0]     req_cmd_i,
  input  logic [CNT_W-1:0]     req_count_i,
  input  logic [ALIGN_W-1:0]   req_align_i,
  input  logic [PAGE_W-1:0]    req_start_i,
  input  logic                 rsp_valid_i,
  input  logic                 rsp_stall_i,
  input  logic [STAT_W-1:0]    rsp_status_i,
  input  logic [PAGE_W-1:0]    rsp_base_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output int                   error_count_o,
  output int                   pending_o
);

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [STAT_W-1:0] status;
    logic [PAGE_W-1:0] base;
  } grant_t;

  bit                page_busy [NUM_PAGES];
  int unsigned       next_fit_page;
  logic [CFG_W-1:0]  total_pages;
  logic [CFG_W-1:0]  reserved_pages;
  grant_t            expected_grants [$];
  int                error_count;
  int                pending;

  assign error_count_o = error_count;
  assign pending_o     = pending;

  task automatic flag_error(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    error_count++;
  endtask

  function automatic int unsigned align_up(input int unsigned x, input int unsigned a);
    return (x + a - 1) & ~(a - 1);
  endfunction

  // Scans aligned bases in [lo, hi) for cnt free pages.
  function automatic bit seek_free_run(input int unsigned cnt, input int unsigned lo,
                                       input int unsigned hi, input int unsigned algn,
                                       output int unsigned found);
    int unsigned b;
    int unsigned t;
    found = 0;
    b = align_up(lo, algn);
    while (b < hi) begin
      if (cnt > hi - b) begin
        return 1'b0;
      end
      t = b;
      while (t < b + cnt && !page_busy[t]) begin
        t++;
      end
      if (t == b + cnt) begin
        found = b;
        return 1'b1;
      end
      b = align_up(t + 1, algn);
    end
    return 1'b0;
  endfunction

  function automatic grant_t serve_request(input logic [CMD_W-1:0] cmd,
                                           input logic [CNT_W-1:0] cnt_f,
                                           input logic [ALIGN_W-1:0] alog,
                                           input logic [PAGE_W-1:0] start_f);
    grant_t      g;
    int unsigned lim;
    int unsigned rsv;
    int unsigned cnt;
    int unsigned start;
    int unsigned algn;
    int unsigned found;
    bit          hit;
    g.cmd    = cmd;
    g.status = ST_BAD;
    g.base   = '0;
    cnt   = 32'(cnt_f);
    start = 32'(start_f);
    algn  = 32'd1 << alog;
    lim   = (total_pages < NUM_PAGES) ? total_pages : NUM_PAGES;
    case (cmd)
      CMD_INIT: begin
        rsv = (reserved_pages < NUM_PAGES) ? reserved_pages : NUM_PAGES;
        for (int unsigned p = 0; p < NUM_PAGES; p++) begin
          page_busy[p] = (p < rsv);
        end
        next_fit_page = (rsv == 0) ? NUM_PAGES - 1 : rsv - 1;
        g.status = ST_OK;
      end
      CMD_ALLOC: begin
        if (cnt != 0) begin
          hit = seek_free_run(cnt, next_fit_page + 1, lim, algn, found);
          if (!hit) begin
            hit = seek_free_run(cnt, 0, (next_fit_page < lim) ? next_fit_page : lim, algn,
                                found);
          end
          if (hit) begin
            for (int unsigned p = found; p < found + cnt; p++) begin
              page_busy[p] = 1'b1;
            end
            next_fit_page = found + cnt - 1;
            g.status = ST_OK;
            g.base   = PAGE_W'(found);
          end else begin
            g.status = ST_NOSPACE;
          end
        end
      end
      CMD_FREE: begin
        if (cnt != 0 && start + cnt <= lim) begin
          for (int unsigned p = start; p < start + cnt; p++) begin
            page_busy[p] = 1'b0;
          end
          g.status = ST_OK;
        end
      end
      default: begin
      end
    endcase
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      foreach (page_busy[p]) begin
        page_busy[p] = 1'b0;
      end
      next_fit_page  = 0;
      total_pages    = TOTAL_RST;
      reserved_pages = RESERVED_RST;
      expected_grants.delete();
      pending        = 0;
      error_count    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TOTAL:    total_pages = cfg_wdata_i;
          REG_RESERVED: reserved_pages = cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (req_valid_i && !req_stall_i) begin
        expected_grants.push_back(serve_request(req_cmd_i, req_count_i, req_align_i,
                                                req_start_i));
      end
      if (rsp_valid_i && !rsp_stall_i) begin
        if (expected_grants.size() == 0) begin
          flag_error($sformatf("result with no request pending: status %0d base %0d",
                               rsp_status_i, rsp_base_i));
        end else begin
          want = expected_grants.pop_front();
          if (rsp_status_i !== want.status) begin
            flag_error($sformatf("cmd %0d: status %0d, expected %0d",
                                 want.cmd, rsp_status_i, want.status));
          end
          if (rsp_base_i !== want.base) begin
            flag_error($sformatf("cmd %0d: base page %0d, expected %0d",
                                 want.cmd, rsp_base_i, want.base));
          end
        end
      end
      pending = expected_grants.size();
    end
  end

endmodule

// ===== tb/bitmap_page_allocator_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the bitmap page allocator: clock, reset, register writes, request and
// result stimulus and the verdict. Depends on bpa_pkg, the block and bpa_grant_checker.
module bitmap_page_allocator_top_tb;
  import bpa_pkg::*;

  localparam int NUM_PAGES = DEF_NUM_PAGES;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 160;
  localparam int HOLD_CYCLES  = 500;
  localparam int TAIL_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 100000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     cmd_i;
  logic [CNT_W-1:0]     page_count_i;
  logic [ALIGN_W-1:0]   align_log2_i;
  logic [PAGE_W-1:0]    start_page_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [STAT_W-1:0]    status_o;
  logic [PAGE_W-1:0]    base_page_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  int          error_count;
  int          pending;
  int unsigned page_lim = NUM_PAGES;
  bit          steady   = 1'b0;
  bit          hold_off = 1'b0;
  int          stuck_cycles = 0;

  always #6 clk_i = ~clk_i;

  bitmap_page_allocator_top #(.NUM_PAGES(NUM_PAGES)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .page_count_i (page_count_i),
    .align_log2_i (align_log2_i),
    .start_page_i (start_page_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .base_page_o  (base_page_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  bpa_grant_checker #(.NUM_PAGES(NUM_PAGES)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (in_valid_i),
    .req_stall_i   (in_stall_o),
    .req_cmd_i     (cmd_i),
    .req_count_i   (page_count_i),
    .req_align_i   (align_log2_i),
    .req_start_i   (start_page_i),
    .rsp_valid_i   (out_valid_o),
    .rsp_stall_i   (out_stall_i),
    .rsp_status_i  (status_o),
    .rsp_base_i    (base_page_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CNT_W-1:0] cnt,
                              input logic [ALIGN_W-1:0] alog, input logic [PAGE_W-1:0] start);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 22) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    cmd_i        = cmd;
    page_count_i = cnt;
    align_log2_i = alog;
    start_page_i = start;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  task automatic random_request();
    int unsigned       pick;
    int unsigned       shape;
    logic [CNT_W-1:0]  cnt;
    logic [ALIGN_W-1:0] alog;
    logic [PAGE_W-1:0] start;
    pick  = $urandom_range(0, 99);
    shape = $urandom_range(0, 99);
    cnt   = CNT_W'($urandom);
    alog  = ALIGN_W'($urandom);
    start = PAGE_W'($urandom);
    if (pick < 2) begin
      send_request(CMD_INIT, cnt, alog, start);
    end else if (pick < 4) begin
      send_request(CMD_UNUSED, cnt, alog, start);
    end else if (pick < 50) begin
      if (shape < 85) begin
        cnt = CNT_W'($urandom_range(1, 32));
      end else if (shape < 95) begin
        cnt = CNT_W'($urandom_range(1, 512));
      end else if (shape < 98) begin
        cnt = CNT_W'($urandom_range(1, NUM_PAGES));
      end
      shape = $urandom_range(0, 99);
      if (shape < 80) begin
        alog = ALIGN_W'($urandom_range(0, 3));
      end else if (shape < 95) begin
        alog = ALIGN_W'($urandom_range(0, 9));
      end
      send_request(CMD_ALLOC, cnt, alog, start);
    end else begin
      if (shape < 90) begin
        start = PAGE_W'($urandom_range(0, page_lim - 1));
        cnt   = CNT_W'($urandom_range(1, 48));
        if (start + cnt > page_lim && $urandom_range(0, 99) < 85) begin
          cnt = CNT_W'(page_lim - start);
        end
      end
      send_request(CMD_FREE, cnt, alog, start);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic set_limits(input int unsigned total, input int unsigned reserved);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = REG_TOTAL;
    cfg_wdata_i = CFG_W'(total);
    @(negedge clk_i);
    cfg_idx_i   = REG_RESERVED;
    cfg_wdata_i = CFG_W'(reserved);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    page_lim    = (total < NUM_PAGES) ? total : NUM_PAGES;
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i = 1'b0;
        hold_off    = 1'b0;
      end else begin
        out_stall_i = !steady && ($urandom_range(0, 99) < 22);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int unsigned totals [NUM_PHASES];
    int unsigned reserves [NUM_PHASES];
    totals   = '{8192, 8192, 16383, 1, 100, 4000, 0, 0};
    reserves = '{4096, 0, 16383, 0, 37, 8192, 0, 0};
    in_valid_i   = 1'b0;
    cmd_i        = CMD_ALLOC;
    page_count_i = '0;
    align_log2_i = '0;
    start_page_i = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_TOTAL;
    cfg_wdata_i  = '0;
    rst_ni       = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The first request finds the map still all free, before any initialize.
    send_request(CMD_ALLOC, 1, 0, 0);
    send_request(CMD_INIT, 0, 0, 0);
    send_request(CMD_ALLOC, 0, 0, 0);
    send_request(CMD_FREE, 0, 0, 0);
    send_request(CMD_UNUSED, 14'h3FFF, 4'hF, 13'h1FFF);
    send_request(CMD_ALLOC, 1, 0, 0);
    send_request(CMD_ALLOC, 3, 2, 0);
    send_request(CMD_ALLOC, 14'h3FFF, 0, 0);
    send_request(CMD_ALLOC, 14'd8192, 0, 0);
    send_request(CMD_ALLOC, 4, 13, 0);
    send_request(CMD_ALLOC, 1, 4'hF, 0);
    send_request(CMD_FREE, 1, 0, 13'h1FFF);
    send_request(CMD_FREE, 2, 0, 13'h1FFF);
    send_request(CMD_FREE, 14'd8192, 0, 0);
    send_request(CMD_FREE, 5, 0, 100);
    send_request(CMD_ALLOC, 4, 13, 0);
    send_request(CMD_ALLOC, 1, 4'hF, 0);
    send_request(CMD_FREE, 14'h3FFF, 0, 0);
    send_request(CMD_FREE, 14'd8192, 0, 0);
    send_request(CMD_ALLOC, 14'd8192, 0, 0);
    send_request(CMD_ALLOC, 14'd8191, 0, 0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      if (ph >= NUM_PHASES - 2) begin
        totals[ph]   = $urandom_range(1, NUM_PAGES);
        reserves[ph] = $urandom_range(0, NUM_PAGES);
      end
      if (ph > 0) begin
        set_limits(totals[ph], reserves[ph]);
      end
      send_request(CMD_INIT, CNT_W'($urandom), ALIGN_W'($urandom), PAGE_W'($urandom));
      if (ph == 2) begin
        hold_off = 1'b1;
      end
      steady = (ph == 4);
      repeat (PHASE_ITEMS) random_request();
      steady = 1'b0;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
